// File: design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the differential-drive odometry block
// Holds the transaction structs, command codes, register indexes, the CORDIC
// arctangent table and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // Default number of CORDIC rotations.
  localparam int CORDIC_STEPS_DEF = 24;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_HALF_TRACK   = 3'd1;
  localparam logic [2:0] REG_WHEEL_LIMIT  = 3'd2;
  localparam logic [2:0] REG_TIME_STEP    = 3'd3;
  localparam logic [2:0] REG_WHEELS_READY = 3'd4;

  // Input opcodes.
  localparam logic [1:0] OP_WHEEL = 2'd0;
  localparam logic [1:0] OP_VW    = 2'd1;
  localparam logic [1:0] OP_RAW   = 2'd2;
  localparam logic [1:0] OP_POSE  = 2'd3;

  // Fixed-point constants: CORDIC start vector and 2^64/(2*pi).
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [63:0] INV_TWO_PI  = 64'sh28BE60DB9391054A;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic               not_ready;
    logic               limited;
  } out_t;

  // Classified command as it travels through the queue.
  typedef enum logic [2:0] {
    CMD_WHEEL,
    CMD_VW,
    CMD_RAW,
    CMD_POSE,
    CMD_REFUSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } cmd_t;

  typedef struct packed {
    logic [30:0] wheel_radius;
    logic [30:0] half_track;
    logic [30:0] wheel_limit;
    logic [30:0] time_step;
    logic        wheels_ready;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Signed value from sign and magnitude, saturated to 32 bits.
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] lo;
    logic [31:0] r;
    lo = mag[31:0];
    if (neg) begin
      r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~lo + 32'd1);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : lo;
    end
    return r;
  endfunction

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front: command intake
// Accepts input transactions, classifies them by opcode and wheel setup, and
// hands the classified command to the queue through a holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ddo_pkg::in_t  in_data,
  input  wire logic          wheels_ready,
  output logic               q_push,
  output ddo_pkg::cmd_t      q_wdata,
  input  wire logic          q_full
);

  logic          hold_valid_r, hold_valid_nxt;
  ddo_pkg::cmd_t hold_r;
  ddo_pkg::cmd_t cls;
  logic          accept;

  // Classification: wheel commands are refused until the wheels are set up.
  always_comb begin
    cls.a = in_data.arg_a;
    cls.b = in_data.arg_b;
    cls.c = in_data.arg_c;
    case (in_data.opcode)
      ddo_pkg::OP_WHEEL: cls.kind = wheels_ready ? ddo_pkg::CMD_WHEEL : ddo_pkg::CMD_REFUSE;
      ddo_pkg::OP_VW:    cls.kind = wheels_ready ? ddo_pkg::CMD_VW : ddo_pkg::CMD_REFUSE;
      ddo_pkg::OP_RAW:   cls.kind = ddo_pkg::CMD_RAW;
      default:           cls.kind = ddo_pkg::CMD_POSE;
    endcase
  end

  // The holding register frees up as soon as the queue takes its command.
  assign q_push   = hold_valid_r && !q_full;
  assign q_wdata  = hold_r;
  assign in_ready = !hold_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cls;
    end
  end

endmodule

`default_nettype wire

// File: design/ddo_fifo.sv
// ----------------------------------------------------------------------------
// ddo_fifo: command queue
// Short first-in first-out queue that decouples the intake from the
// arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ddo_pkg::cmd_t  wdata,
  input  wire logic           pop,
  output ddo_pkg::cmd_t       rdata,
  output ddo_pkg::q_stat_t    stat
);

  localparam int CW = $clog2(ddo_pkg::QDEPTH + 1);

  ddo_pkg::cmd_t               slot_r   [ddo_pkg::QDEPTH];
  ddo_pkg::cmd_t               slot_nxt [ddo_pkg::QDEPTH];
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               wr_cnt;
  logic [ddo_pkg::QAW-1:0]     wr_idx;

  assign stat.full  = (count_r == CW'(ddo_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);

  // The oldest entry always sits in the first slot.
  assign rdata      = slot_r[0];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // A pop moves every entry one slot toward the head; a push fills the
  // first free slot after that move.
  always_comb begin
    wr_cnt = pop ? (count_r - CW'(1)) : count_r;
    wr_idx = wr_cnt[ddo_pkg::QAW-1:0];
    for (int i = 0; i < ddo_pkg::QDEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (pop) begin
      for (int i = 0; i < ddo_pkg::QDEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    if (push) begin
      slot_nxt[wr_idx] = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

`default_nettype wire

// File: design/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul: bit-serial signed multiplier
// Multiplies two signed 64-bit operands into a 128-bit product, one bit of
// the second operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [63:0]  op_a,
  input  wire logic signed [63:0]  op_b,
  output logic                     done,
  output logic signed [127:0]      prod
);

  logic               busy_r, done_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] a_r;
  logic [63:0]        hi_r, lo_r;
  logic signed [64:0] addend, sum;

  // The top bit of the multiplier carries negative weight.
  always_comb begin
    if (!lo_r[0]) begin
      addend = '0;
    end else if (cnt_r == 6'd63) begin
      addend = -{a_r[63], a_r};
    end else begin
      addend = {a_r[63], a_r};
    end
    sum = $signed({hi_r[63], hi_r}) + addend;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-and-add datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= op_a;
      hi_r <= '0;
      lo_r <= op_b;
    end else if (busy_r) begin
      hi_r <= sum[64:1];
      lo_r <= {sum[0], lo_r[63:1]};
    end
  end

endmodule

`default_nettype wire

// File: design/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div: bit-serial unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  dividend,
  input  wire logic [31:0]  divisor,
  output logic              done,
  output logic [63:0]       quot
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [31:0] d_r, rem_r;
  logic [63:0] q_r;
  logic [32:0] shifted, diff;
  logic        ge;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_r, q_r[63]};
    diff    = shifted - {1'b0, d_r};
    ge      = (shifted >= {1'b0, d_r});
  end

  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: design/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back: odometry sequencer
// Takes classified commands from the queue and carries them out on a shared
// serial multiplier, a serial divider and a CORDIC rotator, keeps the pose
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_back #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ddo_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire ddo_pkg::cmd_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ddo_pkg::out_t       out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_CINIT,
    ST_CORDIC,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    STP_VW_MUL,
    STP_VW_DIVL,
    STP_VW_DIVR,
    STP_DRV_CHECK,
    STP_SC_MULL,
    STP_SC_DIVL,
    STP_SC_MULR,
    STP_SC_DIVR,
    STP_SUM_MUL,
    STP_DIF_MUL,
    STP_DIF_DIV,
    STP_P_MUL,
    STP_ANG_MUL,
    STP_DX_MUL1,
    STP_DX_MUL2,
    STP_DY_MUL1,
    STP_DY_MUL2,
    STP_RAW_X,
    STP_RAW_Y
  } step_t;

  state_t              state_r;
  step_t               step_r;
  ddo_pkg::cmd_t       cmd_r;
  logic signed [31:0]  x_r, y_r;
  logic [31:0]         hd_r;
  logic signed [31:0]  wl_r, wr_r, v_r, w_r;
  logic [31:0]         m_r;
  logic signed [63:0]  p_r, t_r, tmp_r;
  logic                nr_r, lmt_r;
  logic signed [35:0]  cx_r, cy_r, cz_r, c_r, s_r;
  logic                flip_r;
  logic [4:0]          ccnt_r;
  logic                out_valid_r;
  ddo_pkg::out_t       out_data_r;

  logic                mul_start, div_start, mul_done, div_done;
  logic signed [63:0]  mul_a, mul_b;
  logic signed [127:0] prod;
  logic [63:0]         div_n, quot;
  logic [31:0]         div_d;

  logic [31:0]         r_eff, b_eff;
  logic [31:0]         al, ar;
  logic signed [32:0]  sum, dif;
  logic [32:0]         abs_sum, abs_dif;
  logic signed [63:0]  num_l, num_r;
  logic [63:0]         abs_num_l, abs_num_r;
  logic signed [63:0]  dt64, d64;
  logic                is_mul, is_div, load_out;
  logic signed [35:0]  zsx, x_it, y_it, z_it, atn;

  // Geometry with zero entries read as one LSB.
  assign r_eff = (cfg.wheel_radius == '0) ? 32'd1 : {1'b0, cfg.wheel_radius};
  assign b_eff = (cfg.half_track == '0) ? 32'd1 : {1'b0, cfg.half_track};
  assign dt64  = $signed({33'd0, cfg.time_step});

  // Wheel speed magnitudes, sum and difference, v/w numerators and the scaled product.
  always_comb begin
    al      = wl_r[31] ? (~wl_r + 32'd1) : wl_r;
    ar      = wr_r[31] ? (~wr_r + 32'd1) : wr_r;
    sum     = {wl_r[31], wl_r} + {wr_r[31], wr_r};
    dif     = {wl_r[31], wl_r} - {wr_r[31], wr_r};
    abs_sum = sum[32] ? 33'(-sum) : sum;
    abs_dif = dif[32] ? 33'(-dif) : dif;
    num_l   = ($signed({{32{cmd_r.a[31]}}, cmd_r.a}) <<< 16) + tmp_r;
    num_r   = ($signed({{32{cmd_r.a[31]}}, cmd_r.a}) <<< 16) - tmp_r;
    abs_num_l = num_l[63] ? 64'(-num_l) : num_l;
    abs_num_r = num_r[63] ? 64'(-num_r) : num_r;
    d64     = $signed(prod[79:16]);
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = 32'd1;
    is_mul = 1'b0;
    is_div = 1'b0;
    case (step_r)
      STP_VW_MUL: begin
        // The v/w conversion uses the half track as written, zero included.
        is_mul = 1'b1;
        mul_a  = $signed({33'd0, cfg.half_track});
        mul_b  = $signed({{32{cmd_r.b[31]}}, cmd_r.b});
      end
      STP_VW_DIVL: begin
        is_div = 1'b1;
        div_n  = abs_num_l;
        div_d  = r_eff;
      end
      STP_VW_DIVR: begin
        is_div = 1'b1;
        div_n  = abs_num_r;
        div_d  = r_eff;
      end
      STP_SC_MULL: begin
        is_mul = 1'b1;
        mul_a  = $signed({32'd0, al});
        mul_b  = $signed({33'd0, cfg.wheel_limit});
      end
      STP_SC_MULR: begin
        is_mul = 1'b1;
        mul_a  = $signed({32'd0, ar});
        mul_b  = $signed({33'd0, cfg.wheel_limit});
      end
      STP_SC_DIVL, STP_SC_DIVR: begin
        is_div = 1'b1;
        div_n  = tmp_r;
        div_d  = m_r;
      end
      STP_SUM_MUL: begin
        is_mul = 1'b1;
        mul_a  = $signed({32'd0, r_eff});
        mul_b  = $signed({31'd0, abs_sum});
      end
      STP_DIF_MUL: begin
        is_mul = 1'b1;
        mul_a  = $signed({32'd0, r_eff});
        mul_b  = $signed({31'd0, abs_dif});
      end
      STP_DIF_DIV: begin
        is_div = 1'b1;
        div_n  = tmp_r;
        div_d  = {b_eff[30:0], 1'b0};
      end
      STP_P_MUL: begin
        is_mul = 1'b1;
        mul_a  = (cmd_r.kind == ddo_pkg::CMD_RAW) ?
                 $signed({{32{cmd_r.c[31]}}, cmd_r.c}) : $signed({{32{w_r[31]}}, w_r});
        mul_b  = dt64;
      end
      STP_ANG_MUL: begin
        is_mul = 1'b1;
        mul_a  = p_r;
        mul_b  = ddo_pkg::INV_TWO_PI;
      end
      STP_DX_MUL1: begin
        is_mul = 1'b1;
        mul_a  = $signed({{32{v_r[31]}}, v_r});
        mul_b  = $signed({{28{c_r[35]}}, c_r});
      end
      STP_DY_MUL1: begin
        is_mul = 1'b1;
        mul_a  = $signed({{32{v_r[31]}}, v_r});
        mul_b  = $signed({{28{s_r[35]}}, s_r});
      end
      STP_DX_MUL2, STP_DY_MUL2: begin
        is_mul = 1'b1;
        mul_a  = t_r;
        mul_b  = dt64;
      end
      STP_RAW_X: begin
        is_mul = 1'b1;
        mul_a  = $signed({{32{cmd_r.a[31]}}, cmd_r.a});
        mul_b  = dt64;
      end
      STP_RAW_Y: begin
        is_mul = 1'b1;
        mul_a  = $signed({{32{cmd_r.b[31]}}, cmd_r.b});
        mul_b  = dt64;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  assign mul_start = (state_r == ST_ISSUE) && is_mul;
  assign div_start = (state_r == ST_ISSUE) && is_div;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One CORDIC rotation per cycle.
  always_comb begin
    zsx = {{4{hd_r[31]}}, hd_r};
    atn = $signed({4'd0, ddo_pkg::atan_val(ccnt_r)});
    if (!cz_r[35]) begin
      x_it = cx_r - (cy_r >>> ccnt_r);
      y_it = cy_r + (cx_r >>> ccnt_r);
      z_it = cz_r - atn;
    end else begin
      x_it = cx_r + (cy_r >>> ccnt_r);
      y_it = cy_r - (cx_r >>> ccnt_r);
      z_it = cz_r + atn;
    end
  end

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot)
  );

  // Sequencer, pose state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STP_DRV_CHECK;
      x_r         <= '0;
      y_r         <= '0;
      hd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_rdata;
            nr_r  <= 1'b0;
            lmt_r <= 1'b0;
            case (q_rdata.kind)
              ddo_pkg::CMD_WHEEL: begin
                wl_r    <= q_rdata.a;
                wr_r    <= q_rdata.b;
                step_r  <= STP_DRV_CHECK;
                state_r <= ST_ISSUE;
              end
              ddo_pkg::CMD_VW: begin
                step_r  <= STP_VW_MUL;
                state_r <= ST_ISSUE;
              end
              ddo_pkg::CMD_RAW: begin
                step_r  <= STP_RAW_X;
                state_r <= ST_ISSUE;
              end
              ddo_pkg::CMD_POSE: begin
                x_r     <= q_rdata.a;
                y_r     <= q_rdata.b;
                p_r     <= $signed({{32{q_rdata.c[31]}}, q_rdata.c}) <<< 16;
                step_r  <= STP_ANG_MUL;
                state_r <= ST_ISSUE;
              end
              default: begin
                nr_r    <= 1'b1;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (step_r == STP_DRV_CHECK) begin
            // Scale both wheels only when the faster one is over the limit.
            m_r <= (al > ar) ? al : ar;
            if (((al > ar) ? al : ar) > {1'b0, cfg.wheel_limit}) begin
              lmt_r  <= 1'b1;
              step_r <= STP_SC_MULL;
            end else begin
              step_r <= STP_SUM_MUL;
            end
          end else begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mul_done || div_done) begin
            state_r <= ST_ISSUE;
            case (step_r)
              STP_VW_MUL: begin
                tmp_r  <= prod[63:0];
                step_r <= STP_VW_DIVL;
              end
              STP_VW_DIVL: begin
                wl_r   <= ddo_pkg::sat_mag(num_l[63], quot);
                step_r <= STP_VW_DIVR;
              end
              STP_VW_DIVR: begin
                wr_r   <= ddo_pkg::sat_mag(num_r[63], quot);
                step_r <= STP_DRV_CHECK;
              end
              STP_SC_MULL: begin
                tmp_r  <= prod[63:0];
                step_r <= STP_SC_DIVL;
              end
              STP_SC_DIVL: begin
                wl_r   <= wl_r[31] ? (~quot[31:0] + 32'd1) : quot[31:0];
                step_r <= STP_SC_MULR;
              end
              STP_SC_MULR: begin
                tmp_r  <= prod[63:0];
                step_r <= STP_SC_DIVR;
              end
              STP_SC_DIVR: begin
                wr_r   <= wr_r[31] ? (~quot[31:0] + 32'd1) : quot[31:0];
                step_r <= STP_SUM_MUL;
              end
              STP_SUM_MUL: begin
                v_r    <= ddo_pkg::sat_mag(sum[32], prod[80:17]);
                step_r <= STP_DIF_MUL;
              end
              STP_DIF_MUL: begin
                tmp_r  <= prod[63:0];
                step_r <= STP_DIF_DIV;
              end
              STP_DIF_DIV: begin
                w_r    <= ddo_pkg::sat_mag(dif[32], quot);
                step_r <= STP_P_MUL;
              end
              STP_P_MUL: begin
                p_r    <= prod[63:0];
                step_r <= STP_ANG_MUL;
              end
              STP_ANG_MUL: begin
                // Radians to binary angle, then on to the kind's next stage.
                case (cmd_r.kind)
                  ddo_pkg::CMD_POSE: begin
                    hd_r    <= prod[95:64];
                    state_r <= ST_DONE;
                  end
                  ddo_pkg::CMD_RAW: begin
                    hd_r    <= hd_r + prod[95:64];
                    state_r <= ST_DONE;
                  end
                  default: begin
                    hd_r    <= hd_r + prod[95:64];
                    state_r <= ST_CINIT;
                  end
                endcase
              end
              STP_DX_MUL1: begin
                t_r    <= prod[93:30];
                step_r <= STP_DX_MUL2;
              end
              STP_DX_MUL2: begin
                x_r    <= ddo_pkg::sat64($signed({{32{x_r[31]}}, x_r}) + d64);
                step_r <= STP_DY_MUL1;
              end
              STP_DY_MUL1: begin
                t_r    <= prod[93:30];
                step_r <= STP_DY_MUL2;
              end
              STP_DY_MUL2: begin
                y_r     <= ddo_pkg::sat64($signed({{32{y_r[31]}}, y_r}) + d64);
                state_r <= ST_DONE;
              end
              STP_RAW_X: begin
                x_r    <= ddo_pkg::sat64($signed({{32{x_r[31]}}, x_r}) + d64);
                step_r <= STP_RAW_Y;
              end
              STP_RAW_Y: begin
                y_r    <= ddo_pkg::sat64($signed({{32{y_r[31]}}, y_r}) + d64);
                step_r <= STP_P_MUL;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_CINIT: begin
          // Fold the heading into the right half plane for the rotator.
          cx_r   <= ddo_pkg::CORDIC_GAIN;
          cy_r   <= '0;
          ccnt_r <= '0;
          if (zsx > 36'sd1073741824) begin
            cz_r   <= zsx - 36'sd2147483648;
            flip_r <= 1'b1;
          end else if (zsx < -36'sd1073741824) begin
            cz_r   <= zsx + 36'sd2147483648;
            flip_r <= 1'b1;
          end else begin
            cz_r   <= zsx;
            flip_r <= 1'b0;
          end
          state_r <= ST_CORDIC;
        end
        ST_CORDIC: begin
          cx_r   <= x_it;
          cy_r   <= y_it;
          cz_r   <= z_it;
          ccnt_r <= ccnt_r + 5'd1;
          if (ccnt_r == 5'(CORDIC_STEPS - 1)) begin
            c_r     <= flip_r ? -x_it : x_it;
            s_r     <= flip_r ? -y_it : y_it;
            step_r  <= STP_DX_MUL1;
            state_r <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_r          <= 1'b1;
            out_data_r.pos_x     <= x_r;
            out_data_r.pos_y     <= y_r;
            out_data_r.heading   <= hd_r;
            out_data_r.not_ready <= nr_r;
            out_data_r.limited   <= lmt_r;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/differential_drive_odometry.sv
// Sequence: a wheel command runs 9 serial operations and the CORDIC rotation,
// 4 more operations when scaled, 3 more for v/w.
// Throughput: one command at a time, set by the shared serial
// multiplier and divider; a 2-entry queue and the result register decouple.
// Reset: synchronous active-low; clears pose, queue, handshakes; loads defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry: planar pose integrator
// Top level: configuration registers, command intake, queue and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ddo_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ddo_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [30:0]   cfg_wdata
);

  ddo_pkg::cfg_t    cfg_r;
  logic             q_push, q_pop;
  ddo_pkg::cmd_t    q_wdata, q_rdata;
  ddo_pkg::q_stat_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_radius <= 31'd65536;
      cfg_r.half_track   <= 31'd65536;
      cfg_r.wheel_limit  <= 31'h7FFF_FFFF;
      cfg_r.time_step    <= 31'd6554;
      cfg_r.wheels_ready <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ddo_pkg::REG_WHEEL_RADIUS: cfg_r.wheel_radius <= cfg_wdata;
        ddo_pkg::REG_HALF_TRACK:   cfg_r.half_track   <= cfg_wdata;
        ddo_pkg::REG_WHEEL_LIMIT:  cfg_r.wheel_limit  <= cfg_wdata;
        ddo_pkg::REG_TIME_STEP:    cfg_r.time_step    <= cfg_wdata;
        ddo_pkg::REG_WHEELS_READY: cfg_r.wheels_ready <= cfg_wdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  ddo_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .wheels_ready (cfg_r.wheels_ready),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_stat.full)
  );

  ddo_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ddo_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (!q_stat.empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A refused command never reports scaling.
  a_refuse_not_limited: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_ready |-> !out_data.limited)
    else $error("refused command reports limited");

  // The queue cannot be full and empty at once.
  a_queue_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A refused command leaves x and the heading where the previous result had them.
  a_refuse_keeps_pose: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || !out_data.not_ready ||
      (out_data.pos_x == $past(out_data.pos_x) && out_data.heading == $past(out_data.heading)))
    else $error("refused command moved the pose");

  // Nothing leaves right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// File: dv/differential_drive_odometry_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test: self-checking bench for the odometry block
// Drives commands over the input channel, writes the geometry registers
// between phases, and compares every pose transaction against a fixed-point
// pose integrator kept inside the bench.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;

  localparam int STALL_LIMIT = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  ddo_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ddo_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [30:0]   cfg_wdata = '0;

  differential_drive_odometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Arctangent of 2^-i in binary angle units.
  localparam int unsigned ATAN_BAM [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};
  localparam logic [63:0] TURNS_PER_RAD = ddo_pkg::INV_TWO_PI;

  // Integrator copy of the geometry registers and the pose.
  logic [30:0] geo_radius = 31'd65536;
  logic [30:0] geo_half_track = 31'd65536;
  logic [30:0] geo_limit = 31'h7FFF_FFFF;
  logic [30:0] geo_dt = 31'd6554;
  logic        geo_ready = 1'b0;
  longint      pose_x = 0;
  longint      pose_y = 0;
  logic [31:0] pose_heading = '0;

  ddo_pkg::out_t pose_expected_q[$];
  int   errors = 0;
  bit   idle_on = 1'b1;
  int   rx_hold = 0;
  int   rx_burst = 0;
  int   quiet_cycles = 0;

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Radians in Q32.32 to binary angle, floored, modulo a full turn.
  function automatic logic [31:0] rad_to_bam(longint p);
    logic [127:0] prod;
    logic [63:0]  hi;
    prod = {64'd0, p} * {64'd0, TURNS_PER_RAD};
    hi = prod[127:64];
    if (p < 0) hi = hi - TURNS_PER_RAD;
    return hi[31:0];
  endfunction

  // Rotation-mode CORDIC with a half-turn fold; returns Q2.30 cos and sin.
  task automatic rotate_unit(input logic [31:0] ang, output longint cs, output longint sn);
    longint z;
    longint x;
    longint y;
    longint t;
    bit     flip;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t;
        z = z - longint'(ATAN_BAM[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t;
        z = z + longint'(ATAN_BAM[i]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic longint scale_to_limit(longint w, longint lim, longint m);
    longint mag;
    mag = abs64(w) * lim / m;
    return (w < 0) ? -mag : mag;
  endfunction

  // Integrates one wheel-speed step; returns 1 when the speeds were scaled.
  task automatic integrate_wheels(input longint wl, input longint wr, output bit lmt);
    longint r, b, lim, dt, m, sum, dif, mag, v, w, cs, sn;
    logic [31:0] th;
    r = (geo_radius != 0) ? longint'(geo_radius) : 1;
    b = (geo_half_track != 0) ? longint'(geo_half_track) : 1;
    lim = longint'(geo_limit);
    dt = longint'(geo_dt);
    m = (abs64(wl) > abs64(wr)) ? abs64(wl) : abs64(wr);
    lmt = 0;
    if (m > lim) begin
      wl = scale_to_limit(wl, lim, m);
      wr = scale_to_limit(wr, lim, m);
      lmt = 1;
    end
    sum = wl + wr;
    dif = wl - wr;
    mag = (r * abs64(sum)) >>> 17;
    v = clamp32((sum < 0) ? -mag : mag);
    mag = r * abs64(dif) / (2 * b);
    if (mag > 64'sd4294967296) mag = 64'sd4294967296;
    w = clamp32((dif < 0) ? -mag : mag);
    th = pose_heading + rad_to_bam(w * dt);
    rotate_unit(th, cs, sn);
    pose_x = clamp32(pose_x + ((((v * cs) >>> 30) * dt) >>> 16));
    pose_y = clamp32(pose_y + ((((v * sn) >>> 30) * dt) >>> 16));
    pose_heading = th;
  endtask

  // Wheel speed for a linear/angular velocity pair, one side per sign.
  function automatic longint wheel_from_vw(longint v, longint w, longint side);
    longint r, num, mag;
    r = (geo_radius != 0) ? longint'(geo_radius) : 1;
    num = v * 65536 + side * (longint'(geo_half_track) * w);
    mag = abs64(num) / r;
    if (mag > 64'sd4294967296) mag = 64'sd4294967296;
    return clamp32((num < 0) ? -mag : mag);
  endfunction

  // Advances the integrator by one command and returns the pose it reports.
  task automatic integrate_command(input ddo_pkg::in_t cmd, output ddo_pkg::out_t pose);
    longint a, b, c, dt;
    bit     lmt;
    a = longint'(cmd.arg_a);
    b = longint'(cmd.arg_b);
    c = longint'(cmd.arg_c);
    dt = longint'(geo_dt);
    pose = '0;
    case (cmd.opcode)
      ddo_pkg::OP_WHEEL, ddo_pkg::OP_VW: begin
        if (!geo_ready) begin
          pose.not_ready = 1'b1;
        end else if (cmd.opcode == ddo_pkg::OP_WHEEL) begin
          integrate_wheels(a, b, lmt);
          pose.limited = lmt;
        end else begin
          integrate_wheels(wheel_from_vw(a, b, 1), wheel_from_vw(a, b, -1), lmt);
          pose.limited = lmt;
        end
      end
      ddo_pkg::OP_RAW: begin
        pose_x = clamp32(pose_x + ((a * dt) >>> 16));
        pose_y = clamp32(pose_y + ((b * dt) >>> 16));
        pose_heading = pose_heading + rad_to_bam(c * dt);
      end
      default: begin
        pose_x = a;
        pose_y = b;
        pose_heading = rad_to_bam(c * 65536);
      end
    endcase
    pose.pos_x = pose_x[31:0];
    pose.pos_y = pose_y[31:0];
    pose.heading = pose_heading;
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // Pose transaction checker and watchdog.
  always @(posedge clk) begin
    ddo_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_expected_q.size() == 0) begin
        report("unexpected pose transaction", out_data.pos_x, 32'd0);
      end else begin
        want = pose_expected_q.pop_front();
        if (out_data.pos_x !== want.pos_x) report("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y !== want.pos_y) report("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.heading !== want.heading)
          report("heading", out_data.heading, want.heading);
        if (out_data.not_ready !== want.not_ready)
          report("not_ready", 32'(out_data.not_ready), 32'(want.not_ready));
        if (out_data.limited !== want.limited)
          report("limited", 32'(out_data.limited), 32'(want.limited));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: long hold-offs on request, otherwise short random stalls while idle_on is set.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_burst > 0) begin
      out_ready <= 1'b0;
      rx_burst--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) rx_burst = $urandom_range(1, 19);
    end
  end

  // Sends one command; keeps valid high unless a random gap follows.
  task automatic send_command(input ddo_pkg::in_t cmd);
    ddo_pkg::out_t pose;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    integrate_command(cmd, pose);
    pose_expected_q = {pose_expected_q, pose};
    if (idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
  endtask

  // Stops offering commands and waits for every pose transaction.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pose_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ddo_pkg::REG_WHEEL_RADIUS: geo_radius = value;
      ddo_pkg::REG_HALF_TRACK:   geo_half_track = value;
      ddo_pkg::REG_WHEEL_LIMIT:  geo_limit = value;
      ddo_pkg::REG_TIME_STEP:    geo_dt = value;
      ddo_pkg::REG_WHEELS_READY: geo_ready = value[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [30:0] r, input logic [30:0] b,
                              input logic [30:0] lim, input logic [30:0] dt);
    write_reg(ddo_pkg::REG_WHEEL_RADIUS, r);
    write_reg(ddo_pkg::REG_HALF_TRACK, b);
    write_reg(ddo_pkg::REG_WHEEL_LIMIT, lim);
    write_reg(ddo_pkg::REG_TIME_STEP, dt);
  endtask

  function automatic ddo_pkg::in_t make_cmd(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c);
    ddo_pkg::in_t cmd;
    cmd.opcode = op;
    cmd.arg_a = a;
    cmd.arg_b = b;
    cmd.arg_c = c;
    return cmd;
  endfunction

  // Argument mix: full range, small speeds, and the corner values.
  function automatic logic [31:0] pick_arg();
    logic [31:0] mag;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 2) - 1;
      default: begin
        mag = $urandom_range(0, 32'h0010_0000);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic ddo_pkg::in_t random_cmd();
    logic [1:0] op;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: op = ddo_pkg::OP_WHEEL;
      4, 5, 6:    op = ddo_pkg::OP_VW;
      7, 8:       op = ddo_pkg::OP_RAW;
      default:    op = ddo_pkg::OP_POSE;
    endcase
    return make_cmd(op, pick_arg(), pick_arg(), pick_arg());
  endfunction

  // Commands before the wheels are set up are refused; raw and pose still run.
  task automatic test_unconfigured;
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h0001_0000, 32'h0002_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_RAW, 32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000));
    send_command(make_cmd(ddo_pkg::OP_POSE, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain();
  endtask

  // Corner values of every opcode under extreme geometries.
  task automatic test_corners;
    set_geometry(31'd65536, 31'd32768, 31'h7FFF_FFFF, 31'd6554);
    write_reg(ddo_pkg::REG_WHEELS_READY, 31'd1);
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h0001_0000, 32'h0001_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h0002_0000, 32'h0000_8000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_POSE, 32'h7FFF_0000, 32'h8001_0000, 32'h0003_243F));
    send_command(make_cmd(ddo_pkg::OP_RAW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_command(make_cmd(ddo_pkg::OP_RAW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    drain();
    // Small limit forces scaling; zero limit stops every wheel.
    write_reg(ddo_pkg::REG_WHEEL_LIMIT, 31'd65536);
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h0004_0000, 32'hFFFE_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h0010_0000, 32'h0001_0000, 32'h0));
    drain();
    write_reg(ddo_pkg::REG_WHEEL_LIMIT, 31'd0);
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h0, 32'h0, 32'h0));
    drain();
    // Zero radius and half track act as one LSB (the v/w conversion uses a zero half track as zero).
    set_geometry(31'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_RAW, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
    drain();
    set_geometry(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    send_command(make_cmd(ddo_pkg::OP_WHEEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h8000_0000, 32'h8000_0000, 32'h0));
    send_command(make_cmd(ddo_pkg::OP_RAW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain();
    // Turning the wheels off again refuses wheel commands.
    write_reg(ddo_pkg::REG_WHEELS_READY, 31'd0);
    send_command(make_cmd(ddo_pkg::OP_VW, 32'h0001_0000, 32'h0001_0000, 32'h0));
    drain();
    write_reg(ddo_pkg::REG_WHEELS_READY, 31'd1);
  endtask

  // Receiver holds off while commands keep coming, so the input stalls.
  task automatic test_backpressure;
    set_geometry(31'd65536, 31'd65536, 31'd655360, 31'd6554);
    rx_hold = 2500;
    for (int i = 0; i < 8; i++) send_command(random_cmd());
    drain();
  endtask

  // Random commands over several geometries; the last phase runs without gaps.
  task automatic test_random_phases;
    logic [30:0] r, b, lim, dt;
    for (int ph = 0; ph < 5; ph++) begin
      r = $urandom_range(0, 1) ? 31'd65536 : 31'($urandom_range(1, 32'h0040_0000));
      b = $urandom_range(0, 1) ? 31'd65536 : 31'($urandom_range(1, 32'h0040_0000));
      case ($urandom_range(0, 3))
        0: lim = 31'h7FFF_FFFF;
        1: lim = 31'($urandom);
        default: lim = 31'($urandom_range(0, 32'h0010_0000));
      endcase
      dt = (ph == 2) ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
      set_geometry(r, b, lim, dt);
      idle_on = (ph != 4);
      for (int i = 0; i < 290; i++) send_command(random_cmd());
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_unconfigured();
    test_corners();
    test_backpressure();
    test_random_phases();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
